FILE: rtl/core/ddem_pkg.sv
// Shared types and constants for the depth discontinuity edge marker.
// Used by ddem_ctrl, ddem_datapath and the top level; no dependencies.
package ddem_pkg;

  // field widths
  localparam int unsigned FW_W      = 11;  // frame_width register
  localparam int unsigned FH_W      = 13;  // frame_height register
  localparam int unsigned EF_W      = 32;  // edge_factor register, Q0.32
  localparam int unsigned ROW_W     = 13;  // arrival row, 0..height+1
  localparam int unsigned SAMPLE_W  = 16;  // depth_sample port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam int unsigned HEIGHT_MAX = 4096;

  // register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [EF_W-1:0] EDGE_FACTOR_RST  = 32'd42950;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_FACTOR  = 2'd2;

  // request types
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // 3x3 window positions, walked one per cycle; the center is masked
  localparam int unsigned   WIN_N    = 9;
  localparam int unsigned   POS_W    = 4;
  localparam logic [POS_W-1:0] POS_LAST = 4'd8;

  typedef struct packed {
    logic             accept;       // input transaction taken
    logic             start_pixel;  // store access, window shift, counters
    logic             issue;        // push one window position into compare pipe
    logic [POS_W-1:0] pos;
    logic             load_out;     // move result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;       // current item produces a result
    logic pipe_busy;  // compare pipe still holds work
    logic out_free;   // output register can take a result
  } dp_status_t;

endpackage

FILE: rtl/core/ddem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the two row stores.
module ddem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ddem_ctrl.sv
// Sequencer for the edge marker: accept, store access, neighbor walk, result.
// Depends on ddem_pkg for command and status types.
module ddem_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ddem_pkg::dp_status_t  status_i,
  output ddem_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_EVAL   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [ddem_pkg::POS_W-1:0]   pos_q, pos_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.start_pixel = 1'b1;
        pos_d             = '0;
        state_d           = status_i.emit ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        cmd_o.issue = 1'b1;
        cmd_o.pos   = pos_q;
        if (pos_q == ddem_pkg::POS_LAST) begin
          state_d = ST_DRAIN;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

endmodule

FILE: rtl/core/ddem_datapath.sv
// Datapath: config registers, raster counters, row stores, 3x3 window,
// three-stage compare pipe and output register. Depends on ddem_pkg, ddem_ram.
module ddem_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ddem_pkg::ctrl_cmd_t               cmd_i,
  output ddem_pkg::dp_status_t              status_o,
  input  logic                              cfg_valid_i,
  input  logic [ddem_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ddem_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              req_type_i,
  input  logic [ddem_pkg::SAMPLE_W-1:0]     depth_sample_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              edge_mark_o,
  output logic                              frame_end_o
);

  localparam int unsigned FW_W   = ddem_pkg::FW_W;
  localparam int unsigned FH_W   = ddem_pkg::FH_W;
  localparam int unsigned EF_W   = ddem_pkg::EF_W;
  localparam int unsigned ROW_W  = ddem_pkg::ROW_W;
  localparam int unsigned WIN_N  = ddem_pkg::WIN_N;
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WEXT_W = (WCNT_W > FW_W) ? WCNT_W : FW_W;
  localparam int unsigned WX_W   = WCNT_W + 1;
  localparam int unsigned CRX_W  = ROW_W + 1;
  localparam int unsigned DB     = DEPTH_BITS;
  localparam int unsigned SQ_W   = 2 * DEPTH_BITS;
  localparam int unsigned SUM_W  = 33;
  localparam int unsigned LIM_W  = EF_W + 1;

  // configuration
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [EF_W-1:0] edge_factor_q;

  // raster position
  logic [ADDR_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] ac_q;
  logic [ROW_W-1:0]  ar_q;
  logic [DB-1:0]     sample_q;

  logic [WCNT_W-1:0] w;
  logic [FH_W-1:0]   h;
  logic [WEXT_W-1:0] fw_ext;
  logic [ADDR_W-1:0] ac_now;

  // window and stores
  logic [DB-1:0] win_q [WIN_N];
  logic [DB-1:0] win_d [WIN_N];
  logic [DB-1:0] up_rd, mid_rd;

  // per-pixel geometry
  logic [WCNT_W-1:0] cc;
  logic [ROW_W-1:0]  cr;
  logic              row0_ok, row2_ok, col0_ok, col2_ok;
  logic [WIN_N-1:0]  mask_d, mask_q;
  logic              last_q;
  logic [WCNT_W-1:0] ac_p1;
  logic              cfg_restart;

  // compare pipe
  logic            s1_valid_q, s2_valid_q;
  logic [SQ_W-1:0] a2_q, b2_q;
  logic [DB-1:0]   diff1_q, diff2_q;
  logic            en1_q, en2_q;
  logic [DB-1:0]   nb_a, nb_b;
  logic [SUM_W-1:0] sum;
  logic [63:0]     prod_q;
  logic            hi_q;
  logic [LIM_W-1:0] limit;
  logic            jump;
  logic            mark_q;

  // output register
  logic out_valid_q, edge_mark_q, frame_end_q;

  // ---------------------------------------------------------------------
  // clamped geometry
  assign fw_ext = WEXT_W'(frame_width_q);

  always_comb begin
    if (fw_ext == '0) begin
      w = WCNT_W'(1);
    end else if (fw_ext > WEXT_W'(MAX_WIDTH)) begin
      w = WCNT_W'(MAX_WIDTH);
    end else begin
      w = WCNT_W'(fw_ext);
    end
    if (frame_height_q == '0) begin
      h = FH_W'(1);
    end else if (frame_height_q > FH_W'(ddem_pkg::HEIGHT_MAX)) begin
      h = FH_W'(ddem_pkg::HEIGHT_MAX);
    end else begin
      h = frame_height_q;
    end
  end

  assign ac_now = (WCNT_W'(col_q) >= w) ? '0 : col_q;

  // ---------------------------------------------------------------------
  // configuration
  assign cfg_restart = cfg_valid_i && (cfg_index_i == ddem_pkg::CFG_FRAME_WIDTH ||
                                       cfg_index_i == ddem_pkg::CFG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ddem_pkg::FRAME_WIDTH_RST;
      frame_height_q <= ddem_pkg::FRAME_HEIGHT_RST;
      edge_factor_q  <= ddem_pkg::EDGE_FACTOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ddem_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        ddem_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        ddem_pkg::CFG_EDGE_FACTOR:  edge_factor_q  <= cfg_data_i[EF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // row stores: read at accept, write back during the store-access cycle
  ddem_ram #(.WIDTH(DB), .DEPTH(MAX_WIDTH)) u_row_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.start_pixel),
    .waddr_i (ac_q),
    .wdata_i (mid_rd),
    .raddr_i (ac_now),
    .rdata_o (up_rd)
  );

  ddem_ram #(.WIDTH(DB), .DEPTH(MAX_WIDTH)) u_row_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.start_pixel),
    .waddr_i (ac_q),
    .wdata_i (sample_q),
    .raddr_i (ac_now),
    .rdata_o (mid_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ac_q     <= ac_now;
      ar_q     <= row_q;
      // flush, or pixel past the frame's last row, enters as zero depth
      sample_q <= (req_type_i == ddem_pkg::REQ_PIXEL && row_q < h) ?
                  depth_sample_i[DB-1:0] : '0;
    end
  end

  // ---------------------------------------------------------------------
  // counters and pixel geometry
  assign ac_p1 = WCNT_W'(ac_q) + WCNT_W'(1);

  assign status_o.emit = (ar_q >= ROW_W'(2)) || (ar_q == ROW_W'(1) && ac_q != '0);

  always_comb begin
    if (ac_q == '0) begin
      cc = w - WCNT_W'(1);
      cr = ar_q - ROW_W'(2);
    end else begin
      cc = WCNT_W'(ac_q) - WCNT_W'(1);
      cr = ar_q - ROW_W'(1);
    end
    row0_ok = (cr != '0);
    row2_ok = (CRX_W'(cr) + CRX_W'(1)) < CRX_W'(h);
    col0_ok = (cc != '0);
    col2_ok = (WX_W'(cc) + WX_W'(1)) < WX_W'(w);
    for (int p = 0; p < WIN_N; p++) begin
      mask_d[p] = (p != 4) &&
                  !((p / 3) == 0 && !row0_ok) && !((p / 3) == 2 && !row2_ok) &&
                  !((p % 3) == 0 && !col0_ok) && !((p % 3) == 2 && !col2_ok);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart || (cmd_i.load_out && last_q)) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.start_pixel) begin
      if (ac_p1 >= w) begin
        col_d = '0;
        row_d = ar_q + ROW_W'(1);
      end else begin
        col_d = ADDR_W'(ac_p1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_pixel) begin
      mask_q <= mask_d;
      last_q <= !row2_ok && !col2_ok;
    end
  end

  // ---------------------------------------------------------------------
  // 3x3 window: rows are upper, middle, current; column 2 is newest
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r * 3]     = win_q[r * 3 + 1];
      win_d[r * 3 + 1] = win_q[r * 3 + 2];
    end
    win_d[2] = up_rd;
    win_d[5] = mid_rd;
    win_d[8] = sample_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_N; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.start_pixel) begin
      for (int i = 0; i < WIN_N; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // compare pipe: squares -> k * (a^2 + b^2) -> limit and compare
  // edge when |a-b| > floor(k * (a^2 + b^2) / 2^32)
  assign nb_a = win_q[4];
  assign nb_b = win_q[cmd_i.pos];

  always_ff @(posedge clk_i) begin
    a2_q    <= SQ_W'(nb_a) * SQ_W'(nb_a);
    b2_q    <= SQ_W'(nb_b) * SQ_W'(nb_b);
    diff1_q <= (nb_a > nb_b) ? (nb_a - nb_b) : (nb_b - nb_a);
    en1_q   <= mask_q[cmd_i.pos];
  end

  assign sum = SUM_W'(a2_q) + SUM_W'(b2_q);

  always_ff @(posedge clk_i) begin
    prod_q  <= 64'(edge_factor_q) * 64'(sum[31:0]);
    hi_q    <= sum[32];
    diff2_q <= diff1_q;
    en2_q   <= en1_q;
  end

  // bit 32 of the sum contributes k itself to the integer part
  assign limit = LIM_W'(prod_q[63:32]) + (hi_q ? LIM_W'(edge_factor_q) : '0);
  assign jump  = en2_q && (LIM_W'(diff2_q) > limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      mark_q     <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
      if (cmd_i.start_pixel) begin
        mark_q <= 1'b0;
      end else if (s2_valid_q) begin
        mark_q <= mark_q | jump;
      end
    end
  end

  assign status_o.pipe_busy = s1_valid_q | s2_valid_q;

  // ---------------------------------------------------------------------
  // output register
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      edge_mark_q <= mark_q;
      frame_end_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign edge_mark_o = edge_mark_q;
  assign frame_end_o = frame_end_q;

endmodule

FILE: rtl/core/depth_discontinuity_edge_mark_top.sv
// After accept come store access and window shift; an item that gives a result then walks
// the nine window positions through the one squaring/multiply compare pipe, drains it and
// waits for a free output register. A new item is taken only once the last one is through.
// Row stores are read at accept and written back in the following cycle.
// Reset: counters zero, window zero, registers at defaults; row stores are not cleared.
// Top level; depends on ddem_pkg, ddem_ctrl, ddem_datapath (and ddem_ram below it).
module depth_discontinuity_edge_mark_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ddem_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ddem_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic [ddem_pkg::SAMPLE_W-1:0]     depth_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              edge_mark_o,
  output logic                              frame_end_o
);

  ddem_pkg::ctrl_cmd_t  cmd;
  ddem_pkg::dp_status_t status;

  // user writes registers only while block is idle (not enforced); writes never held off
  assign cfg_ready_o = 1'b1;

  ddem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .depth_sample_i (depth_sample_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .edge_mark_o    (edge_mark_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for depth_discontinuity_edge_mark_top: raster depth frames in,
// per-pixel edge marks out, checked against an in-bench model of the 3x3 window compare.
// Depends on ddem_pkg and the RTL below the top level.
`timescale 1ns / 1ps

module testbench;
  import ddem_pkg::*;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned DBITS         = 16;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RAND_TARGET   = 380;
  localparam int unsigned CLAMP_ITEMS   = 24;
  localparam int unsigned TIMEOUT_NS    = 10_000_000;

  // index 3 decodes to nothing; writes there must leave the block unchanged
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic                rtype;
    logic [SAMPLE_W-1:0] depth;
  } pixel_item_t;

  typedef struct {
    logic edge_mark;
    logic frame_end;
  } mark_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i     = REQ_PIXEL;
  logic [SAMPLE_W-1:0]  depth_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic                 edge_mark_o;
  logic                 frame_end_o;

  depth_discontinuity_edge_mark_top #(
    .MAX_WIDTH (MAX_W),
    .DEPTH_BITS(DBITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .depth_sample_i(depth_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_mark_o   (edge_mark_o),
    .frame_end_o   (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  pixel_item_t pix_q[$];
  mark_t       mark_q[$];
  pixel_item_t drv_item;
  mark_t       want;

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 57;
  int unsigned queued_items  = 0;
  int unsigned err_cnt       = 0;
  int unsigned hold_left;
  logic        hold_go       = 1'b0;

  // model state: line stores, window, arrival position, registers
  logic [SAMPLE_W-1:0] up_line [MAX_W];
  logic [SAMPLE_W-1:0] mid_line[MAX_W];
  logic [SAMPLE_W-1:0] win     [9];
  int unsigned         col_at     = 0;
  int unsigned         row_at     = 0;
  logic [FW_W-1:0]     width_reg  = FRAME_WIDTH_RST;
  logic [FH_W-1:0]     height_reg = FRAME_HEIGHT_RST;
  logic [EF_W-1:0]     factor_reg = EDGE_FACTOR_RST;

  function automatic int unsigned used_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_h();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
    return 32'(height_reg);
  endfunction

  // |a-b| > floor(k * (a^2 + b^2) / 2^32), split so no term overflows 64 bits
  function automatic logic is_jump(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                                   input logic [EF_W-1:0] k);
    logic [63:0] diff;
    logic [63:0] sq;
    logic [63:0] lim;
    diff = (a > b) ? 64'(a - b) : 64'(b - a);
    sq   = 64'(a) * 64'(a) + 64'(b) * 64'(b);
    lim  = ((64'(k) * 64'(sq[31:0])) >> 32) + 64'(k) * 64'(sq[63:32]);
    return diff > lim;
  endfunction

  task automatic predict_item(input logic rtype, input logic [SAMPLE_W-1:0] depth);
    int unsigned w, h, ac, ar, cc, cr, r, c;
    logic [SAMPLE_W-1:0] smp;
    logic fire, mark, last;
    mark_t res;
    w   = used_w();
    h   = used_h();
    ac  = (col_at >= w) ? 0 : col_at;
    ar  = row_at;
    // flushes, and pixels past the frame's last row, enter as depth zero
    smp = (rtype == REQ_PIXEL && ar < h) ? depth : '0;
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2]       = up_line[ac];
    win[5]       = mid_line[ac];
    win[8]       = smp;
    up_line[ac]  = mid_line[ac];
    mid_line[ac] = smp;
    fire = (ar >= 2) || (ar == 1 && ac >= 1);
    if (ac + 1 >= w) begin
      col_at = 0;
      row_at = ar + 1;
    end else begin
      col_at = ac + 1;
    end
    if (fire) begin
      if (ac == 0) begin
        cc = w - 1;
        cr = ar - 2;
      end else begin
        cc = ac - 1;
        cr = ar - 1;
      end
      mark = 1'b0;
      for (r = 0; r < 3; r++) begin
        if (r == 0 && cr == 0) continue;
        if (r == 2 && cr + 1 >= h) continue;
        for (c = 0; c < 3; c++) begin
          if (r == 1 && c == 1) continue;
          if (c == 0 && cc == 0) continue;
          if (c == 2 && cc + 1 >= w) continue;
          if (is_jump(win[4], win[r*3+c], factor_reg)) mark = 1'b1;
        end
      end
      last          = (cr + 1 >= h) && (cc + 1 >= w);
      res.edge_mark = mark;
      res.frame_end = last;
      mark_q.push_back(res);
      if (last) begin
        col_at = 0;
        row_at = 0;
      end
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    case (idx)
      CFG_FRAME_WIDTH: begin
        width_reg = val[FW_W-1:0];
        col_at    = 0;
        row_at    = 0;
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = val[FH_W-1:0];
        col_at     = 0;
        row_at     = 0;
      end
      CFG_EDGE_FACTOR: factor_reg = val[EF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  // checked at the falling edge so that every update of the rising edge has landed
  task automatic wait_drained();
    do @(negedge clk_i); while (pix_q.size() != 0 || in_valid_i || mark_q.size() != 0);
  endtask

  // items that give no result may still be in flight once the last result is out
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_item(input logic rtype, input logic [SAMPLE_W-1:0] depth);
    pix_q.push_back('{rtype: rtype, depth: depth});
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_depth(input logic [SAMPLE_W-1:0] base);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 12) return '1;
    if (sel < 22) return SAMPLE_W'($urandom);
    return base + SAMPLE_W'($urandom_range(0, (1 << $urandom_range(0, 8)) - 1));
  endfunction

  function automatic logic [EF_W-1:0] pick_factor();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return EDGE_FACTOR_RST;
      3: return $urandom;
      default: return $urandom >> $urandom_range(8, 31);
    endcase
  endfunction

  // one well-formed frame: w*h pixels then w+1 drain items; noisy frames mix in
  // in-frame flushes and pixels during the drain
  task automatic push_frame(input int unsigned w, input int unsigned h, input bit noisy);
    logic [SAMPLE_W-1:0] base;
    int unsigned i;
    base = SAMPLE_W'($urandom_range(0, (1 << $urandom_range(4, 16)) - 1));
    for (i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(9) == 0) add_item(REQ_FLUSH, SAMPLE_W'($urandom));
      else add_item(REQ_PIXEL, pick_depth(base));
    end
    for (i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(3) == 0) add_item(REQ_PIXEL, SAMPLE_W'($urandom));
      else add_item(REQ_FLUSH, SAMPLE_W'($urandom));
    end
    queued_items += w * h + w + 1;
  endtask

  // driver: a transaction completes on valid && ready; the model runs on it right there
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_item(req_type_i, depth_sample_i);
      if (!in_valid_i || in_ready_o) begin
        if (pix_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = pix_q.pop_front();
          in_valid_i     <= 1'b1;
          req_type_i     <= drv_item.rtype;
          depth_sample_i <= drv_item.depth;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mark_q.size() == 0) begin
        $error("result with nothing pending: edge_mark=%0b frame_end=%0b",
               edge_mark_o, frame_end_o);
        err_cnt++;
      end else begin
        want = mark_q.pop_front();
        if (edge_mark_o !== want.edge_mark) begin
          $error("edge_mark: expected %0b, got %0b", want.edge_mark, edge_mark_o);
          err_cnt++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned w, h, n, rand_start;
    foreach (up_line[i]) begin
      up_line[i]  = '0;
      mid_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // 3x3 frame at default factor: zero pairs, full-scale jumps, in-frame flush,
    // pixel arriving during the drain
    write_reg(CFG_FRAME_WIDTH, 32'd3);
    write_reg(CFG_FRAME_HEIGHT, 32'd3);
    add_item(REQ_PIXEL, 16'd0);
    add_item(REQ_PIXEL, 16'd0);
    add_item(REQ_PIXEL, 16'hFFFF);
    add_item(REQ_PIXEL, 16'd1);
    add_item(REQ_FLUSH, 16'h5A5A);
    add_item(REQ_PIXEL, 16'd1000);
    add_item(REQ_PIXEL, 16'd1010);
    add_item(REQ_PIXEL, 16'd0);
    add_item(REQ_PIXEL, 16'hFFFF);
    add_item(REQ_FLUSH, 16'hFFFF);
    add_item(REQ_FLUSH, 16'd0);
    add_item(REQ_PIXEL, 16'h1234);
    add_item(REQ_FLUSH, 16'hA5A5);
    settle();

    // zero factor, height zero clamps to one row
    write_reg(CFG_FRAME_WIDTH, 32'd2);
    write_reg(CFG_FRAME_HEIGHT, 32'd0);
    write_reg(CFG_EDGE_FACTOR, 32'd0);
    add_item(REQ_PIXEL, 16'd5);
    add_item(REQ_PIXEL, 16'd5);
    add_item(REQ_PIXEL, 16'd7);
    add_item(REQ_FLUSH, 16'd0);
    add_item(REQ_FLUSH, 16'd0);
    settle();

    // full factor, width zero clamps to a single column
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    write_reg(CFG_FRAME_WIDTH, 32'd0);
    write_reg(CFG_FRAME_HEIGHT, 32'd3);
    write_reg(CFG_EDGE_FACTOR, 32'hFFFF_FFFF);
    add_item(REQ_PIXEL, 16'd0);
    add_item(REQ_PIXEL, 16'd1);
    add_item(REQ_PIXEL, 16'hFFFF);
    add_item(REQ_FLUSH, 16'd0);
    add_item(REQ_FLUSH, 16'd0);
    settle();

    // back-pressure: output held off while two frames are offered, then the
    // sender waits for every result before sending one more
    rand_start = queued_items;
    write_reg(CFG_FRAME_WIDTH, 32'd8);
    write_reg(CFG_FRAME_HEIGHT, 32'd6);
    write_reg(CFG_EDGE_FACTOR, EDGE_FACTOR_RST);
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    push_frame(8, 6, 1'b0);
    push_frame(8, 6, 1'b1);
    wait_drained();
    push_frame(8, 6, 1'b0);

    while (queued_items - rand_start < RAND_TARGET) begin
      n = queued_items - rand_start;
      if (n < RAND_TARGET / 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 57;
      end else if (n < 2 * RAND_TARGET / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      // a skipped geometry write lets a partial frame carry on under a new factor
      if ($urandom_range(7) != 0) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
        write_reg(CFG_FRAME_WIDTH, ($urandom & ~32'h7FF) | w);
        write_reg(CFG_FRAME_HEIGHT, ($urandom & ~32'h1FFF) | h);
      end
      write_reg(CFG_EDGE_FACTOR, pick_factor());
      repeat ($urandom_range(1, 3)) push_frame(used_w(), used_h(), $urandom_range(3) == 0);
      if ($urandom_range(5) == 0) begin
        // partial frame, abandoned by the next geometry write
        n = $urandom_range(1, used_w() * used_h());
        repeat (n) add_item(REQ_PIXEL, pick_depth(SAMPLE_W'($urandom)));
        queued_items += n;
      end
    end

    // largest geometry, each through its clamp; short partial frames only
    settle();
    write_reg(CFG_FRAME_WIDTH, 32'h0000_07FF);
    write_reg(CFG_FRAME_HEIGHT, 32'd1);
    write_reg(CFG_EDGE_FACTOR, EDGE_FACTOR_RST);
    repeat (CLAMP_ITEMS) add_item(REQ_PIXEL, pick_depth(SAMPLE_W'($urandom)));
    settle();
    write_reg(CFG_FRAME_WIDTH, 32'd1);
    write_reg(CFG_FRAME_HEIGHT, 32'h0000_1FFF);
    write_reg(CFG_EDGE_FACTOR, pick_factor());
    repeat (CLAMP_ITEMS) add_item(REQ_PIXEL, pick_depth(SAMPLE_W'($urandom)));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ddem_pkg.sv
rtl/core/ddem_ram.sv
rtl/core/ddem_ctrl.sv
rtl/core/ddem_datapath.sv
rtl/core/depth_discontinuity_edge_mark_top.sv
tb/sv/testbench.sv
